@@ sv/lhc_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lhc_pkg
// shared widths, function codes, register indexes and cordic constants
// ============================================================================
package lhc_pkg;

    localparam int POS_W      = 32;
    localparam int Q_W        = 16;
    localparam int DIST_W     = 24;
    localparam int SPD_W      = 15;
    localparam int TURN_W     = 16;
    localparam int ANG_W      = 16;
    localparam int ERR_W      = 17;
    localparam int DIFF_W     = 33;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int COR_W      = 38;
    localparam int Z_W        = 21;
    localparam int STEP_W     = 4;
    localparam int PROD_W     = 48;

    typedef logic [1:0] t_func;
    localparam t_func FUNC_WAYPOINT = 2'd0;
    localparam t_func FUNC_CLEAR    = 2'd1;
    localparam t_func FUNC_ODOM     = 2'd2;
    localparam t_func FUNC_TICK     = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LOOKAHEAD = 3'd0;
    localparam t_cfg_idx CFG_GOAL_TOL  = 3'd1;
    localparam t_cfg_idx CFG_CRUISE    = 3'd2;
    localparam t_cfg_idx CFG_SLOW      = 3'd3;
    localparam t_cfg_idx CFG_GAIN      = 3'd4;
    localparam t_cfg_idx CFG_TURN_LIM  = 3'd5;
    localparam t_cfg_idx CFG_HEAD_LIM  = 3'd6;

    localparam logic [DIST_W-1:0] RST_LOOKAHEAD = 24'd52429;
    localparam logic [DIST_W-1:0] RST_GOAL_TOL  = 24'd22938;
    localparam logic [SPD_W-1:0]  RST_CRUISE    = 15'd1024;
    localparam logic [SPD_W-1:0]  RST_SLOW      = 15'd205;
    localparam logic [SPD_W-1:0]  RST_GAIN      = 15'd6144;
    localparam logic [SPD_W-1:0]  RST_TURN_LIM  = 15'd4096;
    localparam logic [SPD_W-1:0]  RST_HEAD_LIM  = 15'd8192;

    localparam logic signed [Z_W-1:0]   PI_Q16    = 21'sd205887;
    localparam logic signed [Z_W-1:0]   PI_Q13_Z  = 21'sd25736;
    localparam logic signed [ERR_W-1:0] PI_Q13_E  = 17'sd25736;
    localparam logic signed [ERR_W-1:0] TWO_PI_E  = 17'sd51472;
    localparam logic signed [COR_W-1:0] COR_ONE   = 38'sd1073741824;
    localparam logic [PROD_W-1:0]       ROUND_Q13 = 48'd4096;

    // arctangent of 2^-i in Q.16 rad
    function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            4'd0:    v = 21'sd51472;
            4'd1:    v = 21'sd30385;
            4'd2:    v = 21'sd16055;
            4'd3:    v = 21'sd8150;
            4'd4:    v = 21'sd4091;
            4'd5:    v = 21'sd2047;
            4'd6:    v = 21'sd1024;
            4'd7:    v = 21'sd512;
            4'd8:    v = 21'sd256;
            4'd9:    v = 21'sd128;
            4'd10:   v = 21'sd64;
            4'd11:   v = 21'sd32;
            4'd12:   v = 21'sd16;
            4'd13:   v = 21'sd8;
            4'd14:   v = 21'sd4;
            4'd15:   v = 21'sd2;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/lhc_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lhc channel interfaces
// input item, result item and register write channels
// ============================================================================
interface lhc_in_if;
    logic                                valid;
    logic                                ready;
    lhc_pkg::t_func                      func;
    logic signed [lhc_pkg::POS_W-1:0]    pos_x;
    logic signed [lhc_pkg::POS_W-1:0]    pos_y;
    logic signed [lhc_pkg::Q_W-1:0]      quat_x;
    logic signed [lhc_pkg::Q_W-1:0]      quat_y;
    logic signed [lhc_pkg::Q_W-1:0]      quat_z;
    logic signed [lhc_pkg::Q_W-1:0]      quat_w;
    logic                                final_point;
    modport source (output valid, func, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    final_point, input ready);
    modport sink (input valid, func, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                  final_point, output ready);
endinterface

interface lhc_out_if;
    logic                                valid;
    logic                                ready;
    logic [lhc_pkg::SPD_W-1:0]           forward_cmd;
    logic signed [lhc_pkg::TURN_W-1:0]   turn_cmd;
    modport source (output valid, forward_cmd, turn_cmd, input ready);
    modport sink (input valid, forward_cmd, turn_cmd, output ready);
endinterface

interface lhc_cfg_if;
    logic                                valid;
    logic                                ready;
    lhc_pkg::t_cfg_idx                   index;
    logic [lhc_pkg::CFG_DATA_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/lhc_wp_mem.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lhc_wp_mem
// waypoint store, one write port and one registered read port
// ============================================================================
module lhc_wp_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [lhc_pkg::POS_W-1:0]     i_wx,
    input  logic [lhc_pkg::POS_W-1:0]     i_wy,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [lhc_pkg::POS_W-1:0]     o_rx,
    output logic [lhc_pkg::POS_W-1:0]     o_ry
);
    import lhc_pkg::*;

    logic [2*POS_W-1:0] r_mem [DEPTH];
    logic [2*POS_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wy, i_wx};
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rx = r_rdata[POS_W-1:0];
    assign o_ry = r_rdata[2*POS_W-1:POS_W];

endmodule

@@ sv/lhc_cordic.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lhc_cordic
// iterative vectoring cordic, atan2 in q3.13 rad, one step per cycle
// ============================================================================
module lhc_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [lhc_pkg::COR_W-1:0]     i_y,
    input  logic signed [lhc_pkg::COR_W-1:0]     i_x,
    output logic                                 o_done,
    output logic signed [lhc_pkg::ANG_W-1:0]     o_angle
);
    import lhc_pkg::*;

    logic signed [COR_W-1:0] r_x, r_y, n_x, n_y, xs, ys;
    logic signed [Z_W-1:0]   r_z, n_z, zr, zc;
    logic [STEP_W-1:0]       r_step;
    logic                    r_busy, r_done;
    logic signed [ANG_W-1:0] r_angle;

    always_comb begin
        xs = r_x >>> r_step;
        ys = r_y >>> r_step;
        if (r_y > 0) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + atan_step(r_step);
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - atan_step(r_step);
        end
        // round half up to q3.13, clamp to +-pi
        zr = (n_z + 21'sd4) >>> 3;
        if (zr > PI_Q13_Z) begin
            zc = PI_Q13_Z;
        end else if (zr < -PI_Q13_Z) begin
            zc = -PI_Q13_Z;
        end else begin
            zc = zr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            // done pulses for a zero vector at start, or after the last step
            r_done <= i_start ? (i_x == 0 && i_y == 0) : (r_busy && r_step == '1);
            if (i_start) begin
                if (i_x == 0 && i_y == 0) begin
                    r_angle <= '0;
                end else begin
                    r_busy <= 1'b1;
                    r_step <= '0;
                    // left half plane: rotate by pi first
                    if (i_x < 0) begin
                        r_x <= -i_x;
                        r_y <= -i_y;
                        r_z <= (i_y >= 0) ? PI_Q16 : -PI_Q16;
                    end else begin
                        r_x <= i_x;
                        r_y <= i_y;
                        r_z <= '0;
                    end
                end
            end else if (r_busy) begin
                r_x    <= n_x;
                r_y    <= n_y;
                r_z    <= n_z;
                r_step <= r_step + 4'd1;
                if (r_step == '1) begin
                    r_busy  <= 1'b0;
                    r_angle <= ANG_W'(zc);
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;

endmodule

@@ sv/lookahead_heading_controller.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lookahead_heading_controller
// path following speed command generator with lookahead target selection
// ============================================================================
// usage:
//   i_in   input items: waypoint, empty path, odometry, control tick
//   o_out  result items: forward_cmd and turn_cmd, at most one per item
//   i_cfg  register writes, always ready; write only while no item is in flight
// one item is worked at a time; i_in.ready is high only in the idle state
// waypoint item: written straight into the waypoint memory
// empty path item: a zero result, loaded through the emit state into the result register
// odometry item: 4 shared multiply steps, then the cordic start, its 16 steps
//   and its done pulse
// control tick: squared thresholds, a goal check on the last entry, then a scan
//   from entry 0 until the lookahead hit or the last entry; each scanned entry
//   costs a memory read, a difference and two squaring steps on one 24x24
//   multiplier; a stop at the goal emits a zero result, a silent tick none
// results sit in an output register; a stalled receiver holds it, and the
//   block still takes the next item; a new result waits in the emit state
// reset clears path, odometry and output state and loads register defaults;
//   the waypoint memory is not cleared, only written entries are ever read
// ============================================================================
module lookahead_heading_controller #(
    parameter int MAX_WAYPOINTS = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lhc_in_if.sink   i_in,
    lhc_out_if.source o_out,
    lhc_cfg_if.sink  i_cfg
);
    import lhc_pkg::*;

    localparam int IDX_W = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);
    localparam int ACC_W = 33;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WAYPOINTS);

    typedef enum logic [4:0] {
        S_IDLE, S_OD_M0, S_OD_M1, S_OD_M2, S_OD_M3, S_OD_COR,
        S_TK_T2, S_TK_L2, S_RD, S_DIF, S_SQX, S_SQY,
        S_TK_COR, S_MUL, S_FIN, S_EMIT
    } t_state;

    // configuration registers
    logic [DIST_W-1:0] r_lookahead, r_goal_tol;
    logic [SPD_W-1:0]  r_cruise, r_slow, r_gain, r_turn_lim, r_head_lim;

    // control state
    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_path_ready, r_odom_ready;
    logic              r_goal_mode;
    logic [IDX_W-1:0]  r_idx;
    logic              r_ov;
    logic              r_cor_start;

    // datapath registers
    logic signed [POS_W-1:0]  r_robot_x, r_robot_y;
    logic signed [ANG_W-1:0]  r_heading;
    logic signed [Q_W-1:0]    r_qx, r_qy, r_qz, r_qw;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [COR_W-1:0]  r_cor_y, r_cor_x;
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic [DIST_W-1:0]        r_mx, r_my;
    logic                     r_far;
    logic [PROD_W-1:0]        r_t2, r_l2, r_sq, r_prod;
    logic signed [ERR_W-1:0]  r_err;
    logic [SPD_W-1:0]         r_res_fwd, r_out_fwd;
    logic signed [TURN_W-1:0] r_res_turn, r_out_turn;

    // combinational signals
    logic                     in_xfer;
    logic signed [Q_W-1:0]    sa, sb;
    logic signed [2*Q_W-1:0]  smul;
    logic signed [ACC_W-1:0]  acc_sum;
    logic [DIST_W-1:0]        ua, ub;
    logic [PROD_W-1:0]        umul;
    logic [PROD_W:0]          dsum;
    logic signed [DIFF_W-1:0] dx, dy;
    logic [DIFF_W-1:0]        mx, my;
    logic [IDX_W-1:0]         last_idx;
    logic signed [ERR_W-1:0]  err_raw, err_wrap;
    logic [ANG_W-1:0]         abs_err;
    logic [PROD_W-1:0]        turn_mag;
    logic [SPD_W-1:0]         turn_clamp;
    logic signed [TURN_W-1:0] turn_signed;
    logic                     mem_we, mem_re;
    logic [IDX_W-1:0]         mem_waddr;
    logic [POS_W-1:0]         rd_x, rd_y;
    logic                     cor_done;
    logic signed [ANG_W-1:0]  cor_angle;

    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign last_idx    = IDX_W'(r_count - CNT_W'(1));

    // waypoint write; a waypoint after a complete path starts a new one at entry 0
    assign mem_we    = in_xfer && (i_in.func == FUNC_WAYPOINT)
                       && (r_path_ready || (r_count < CNT_MAX));
    assign mem_waddr = r_path_ready ? '0 : r_count[IDX_W-1:0];
    assign mem_re    = (r_state == S_RD);

    lhc_wp_mem #(
        .DEPTH (MAX_WAYPOINTS),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wx    (i_in.pos_x),
        .i_wy    (i_in.pos_y),
        .i_re    (mem_re),
        .i_raddr (r_idx),
        .o_rx    (rd_x),
        .o_ry    (rd_y)
    );

    lhc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cor_start),
        .i_y     (r_cor_y),
        .i_x     (r_cor_x),
        .o_done  (cor_done),
        .o_angle (cor_angle)
    );

    // signed 16x16 multiplier for the quaternion to yaw terms
    always_comb begin
        case (r_state)
            S_OD_M0: begin sa = r_qw; sb = r_qz; end
            S_OD_M1: begin sa = r_qx; sb = r_qy; end
            S_OD_M2: begin sa = r_qy; sb = r_qy; end
            S_OD_M3: begin sa = r_qz; sb = r_qz; end
            default: begin sa = '0;   sb = '0;   end
        endcase
        smul    = sa * sb;
        acc_sum = r_acc + ACC_W'(smul);
    end

    // unsigned 24x24 multiplier shared by thresholds, distances and turn gain
    always_comb begin
        case (r_state)
            S_TK_T2: begin ua = r_goal_tol;    ub = r_goal_tol;    end
            S_TK_L2: begin ua = r_lookahead;   ub = r_lookahead;   end
            S_SQX:   begin ua = r_mx;          ub = r_mx;          end
            S_SQY:   begin ua = r_my;          ub = r_my;          end
            S_MUL:   begin ua = DIST_W'(r_gain); ub = DIST_W'(abs_err); end
            default: begin ua = '0;            ub = '0;            end
        endcase
        umul = ua * ub;
        dsum = {1'b0, r_sq} + {1'b0, umul};
    end

    // distance terms of the entry just read
    always_comb begin
        dx = DIFF_W'($signed(rd_x)) - DIFF_W'(r_robot_x);
        dy = DIFF_W'($signed(rd_y)) - DIFF_W'(r_robot_y);
        mx = (dx < 0) ? DIFF_W'(-dx) : DIFF_W'(dx);
        my = (dy < 0) ? DIFF_W'(-dy) : DIFF_W'(dy);
    end

    // heading error wrap, turn rounding and clamp
    always_comb begin
        err_raw = ERR_W'(cor_angle) - ERR_W'(r_heading);
        if (err_raw > PI_Q13_E) begin
            err_wrap = err_raw - TWO_PI_E;
        end else if (err_raw < -PI_Q13_E) begin
            err_wrap = err_raw + TWO_PI_E;
        end else begin
            err_wrap = err_raw;
        end
        abs_err  = (r_err < 0) ? ANG_W'(-r_err) : ANG_W'(r_err);
        turn_mag = (r_prod + ROUND_Q13) >> 13;
        if (turn_mag > PROD_W'(r_turn_lim)) begin
            turn_clamp = r_turn_lim;
        end else begin
            turn_clamp = turn_mag[SPD_W-1:0];
        end
        turn_signed = (r_err < 0) ? -$signed({1'b0, turn_clamp})
                                  : $signed({1'b0, turn_clamp});
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookahead <= RST_LOOKAHEAD;
            r_goal_tol  <= RST_GOAL_TOL;
            r_cruise    <= RST_CRUISE;
            r_slow      <= RST_SLOW;
            r_gain      <= RST_GAIN;
            r_turn_lim  <= RST_TURN_LIM;
            r_head_lim  <= RST_HEAD_LIM;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_LOOKAHEAD: r_lookahead <= i_cfg.data;
                CFG_GOAL_TOL:  r_goal_tol  <= i_cfg.data;
                CFG_CRUISE:    r_cruise    <= i_cfg.data[SPD_W-1:0];
                CFG_SLOW:      r_slow      <= i_cfg.data[SPD_W-1:0];
                CFG_GAIN:      r_gain      <= i_cfg.data[SPD_W-1:0];
                CFG_TURN_LIM:  r_turn_lim  <= i_cfg.data[SPD_W-1:0];
                CFG_HEAD_LIM:  r_head_lim  <= i_cfg.data[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer with state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_path_ready <= 1'b0;
            r_odom_ready <= 1'b0;
            r_goal_mode  <= 1'b0;
            r_idx        <= '0;
            r_ov         <= 1'b0;
            r_cor_start  <= 1'b0;
            r_robot_x    <= '0;
            r_robot_y    <= '0;
            r_heading    <= '0;
        end else begin
            // output transfer frees the register; the emit state reloads it itself
            if (r_ov && o_out.ready && (r_state != S_EMIT)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        unique case (i_in.func)
                            FUNC_WAYPOINT: begin
                                if (r_path_ready) begin
                                    r_count <= CNT_W'(1);
                                end else if (r_count < CNT_MAX) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                                r_path_ready <= i_in.final_point;
                            end
                            FUNC_CLEAR: begin
                                r_count      <= '0;
                                r_path_ready <= 1'b1;
                                r_res_fwd    <= '0;
                                r_res_turn   <= '0;
                                r_state      <= S_EMIT;
                            end
                            FUNC_ODOM: begin
                                r_robot_x <= i_in.pos_x;
                                r_robot_y <= i_in.pos_y;
                                r_qx      <= i_in.quat_x;
                                r_qy      <= i_in.quat_y;
                                r_qz      <= i_in.quat_z;
                                r_qw      <= i_in.quat_w;
                                r_state   <= S_OD_M0;
                            end
                            FUNC_TICK: begin
                                // silent until a complete path and odometry exist
                                if (r_path_ready && r_odom_ready) begin
                                    r_res_fwd  <= '0;
                                    r_res_turn <= '0;
                                    if (r_count == '0) begin
                                        r_state <= S_EMIT;
                                    end else begin
                                        r_state <= S_TK_T2;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // yaw: sin term 2*(w*z + x*y), cos term 1 - 2*(y*y + z*z)
                S_OD_M0: begin
                    r_acc   <= ACC_W'(smul);
                    r_state <= S_OD_M1;
                end
                S_OD_M1: begin
                    r_cor_y <= COR_W'(acc_sum) <<< 1;
                    r_state <= S_OD_M2;
                end
                S_OD_M2: begin
                    r_acc   <= ACC_W'(smul);
                    r_state <= S_OD_M3;
                end
                S_OD_M3: begin
                    r_cor_x     <= COR_ONE - (COR_W'(acc_sum) <<< 1);
                    r_cor_start <= 1'b1;
                    r_state     <= S_OD_COR;
                end
                S_OD_COR: begin
                    r_cor_start <= 1'b0;
                    if (cor_done) begin
                        r_heading    <= cor_angle;
                        r_odom_ready <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                // squared thresholds, then the goal check on the last entry
                S_TK_T2: begin
                    r_t2    <= umul;
                    r_state <= S_TK_L2;
                end
                S_TK_L2: begin
                    r_l2        <= umul;
                    r_goal_mode <= 1'b1;
                    r_idx       <= last_idx;
                    r_state     <= S_RD;
                end
                S_RD: begin
                    r_state <= S_DIF;
                end
                S_DIF: begin
                    r_dx    <= dx;
                    r_dy    <= dy;
                    r_mx    <= mx[DIST_W-1:0];
                    r_my    <= my[DIST_W-1:0];
                    // beyond 2^24-1 in either axis counts as farther than any threshold
                    r_far   <= (mx[DIFF_W-1:DIST_W] != '0) || (my[DIFF_W-1:DIST_W] != '0);
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    r_sq    <= umul;
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    if (r_goal_mode) begin
                        if (!r_far && (dsum <= {1'b0, r_t2})) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_goal_mode <= 1'b0;
                            r_idx       <= '0;
                            r_state     <= S_RD;
                        end
                    end else if (r_far || (dsum >= {1'b0, r_l2}) || (r_idx == last_idx)) begin
                        // target found, or fall back to the last waypoint
                        r_cor_y     <= COR_W'(r_dy);
                        r_cor_x     <= COR_W'(r_dx);
                        r_cor_start <= 1'b1;
                        r_state     <= S_TK_COR;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_TK_COR: begin
                    r_cor_start <= 1'b0;
                    if (cor_done) begin
                        r_err   <= err_wrap;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= umul;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_res_turn <= turn_signed;
                    r_res_fwd  <= (abs_err > ANG_W'(r_head_lim)) ? r_slow : r_cruise;
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_ov || o_out.ready) begin
                        r_out_fwd  <= r_res_fwd;
                        r_out_turn <= r_res_turn;
                        r_ov       <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.forward_cmd = r_out_fwd;
    assign o_out.turn_cmd    = r_out_turn;

endmodule
